FILE: src/rpm_assist_power_limiter_defines.svh
// Assertion macros shared by the modules of the rpm assist power limiter.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef RPM_ASSIST_POWER_LIMITER_DEFINES_SVH
`define RPM_ASSIST_POWER_LIMITER_DEFINES_SVH

`define RPAL_ASSERT_IMM(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpal assertion failed");

`define RPAL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpal assertion failed");

`endif

FILE: src/rpal_pkg.sv
// Package of the rpm assist power limiter: widths, register indexes, constants
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package rpal_pkg;

    localparam int NEUTRAL_NOM_DEFAULT = 50;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HYST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_START   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ENABLE  = 3'd7;

    localparam int DIV_NUM_W = 22;
    localparam int DIV_DEN_W = 15;
    localparam int DIV_CNT_W = 5;

    localparam logic [31:0] HOLD_OFF_MS   = 32'd500;
    localparam logic [31:0] ADJUST_MS     = 32'd200;
    localparam logic signed [17:0] ERR_HIGH1 = 18'sd500;
    localparam logic signed [17:0] ERR_HIGH2 = 18'sd2000;
    localparam logic signed [17:0] ERR_HIGH3 = 18'sd4000;
    localparam logic signed [17:0] ERR_LOW   = -18'sd1000;
    localparam logic [7:0] CEIL_LINK_DOWN = 8'd60;
    localparam logic [7:0] CEIL_LINK_UP   = 8'd70;
    localparam logic [7:0] FLOOR_PERCENT  = 8'd10;
    localparam logic [7:0] TOP_STEP_PERCENT = 8'd95;
    localparam logic [7:0] FULL_PERCENT   = 8'd100;

    typedef logic [2:0] div_sel_t;
    localparam div_sel_t SEL_T60   = 3'd0;
    localparam div_sel_t SEL_T70   = 3'd1;
    localparam div_sel_t SEL_SCALE = 3'd2;
    localparam div_sel_t SEL_BLEND = 3'd3;
    localparam div_sel_t SEL_CEIL  = 3'd4;

    typedef struct packed {
        logic     load;
        logic     trans;
        logic     div_start;
        div_sel_t div_sel;
        logic     limit;
        logic     blend;
        logic     fin;
    } dp_cmd_t;

    typedef struct packed {
        logic assist;
        logic in_window;
        logic in_ramp;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/rpm_assist_power_limiter.sv
// Top level of the rpm assist power limiter: joins the controller and the datapath.
// Depends on rpal_pkg, rpal_ctrl and rpal_datapath.
//
// One item is taken at a time. An item in a mode other than assist passes through the
// idle, transition and finish states only. In assist mode the shared serial divider
// sets the pace: two divisions always, two more inside the rpm blending window and
// one in the high-rpm rampdown band. A finished result waits in the output register
// while the next item is accepted.
`default_nettype none

module rpm_assist_power_limiter #(
    parameter int NEUTRAL_NOM_PERCENT = rpal_pkg::NEUTRAL_NOM_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rpal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rpal_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [6:0]                      requested_percent,
    input  wire logic                            assist_mode,
    input  wire logic [15:0]                     engine_rpm,
    input  wire logic [31:0]                     now_ms,
    input  wire logic                            link_up,
    input  wire logic signed [15:0]              battery_power_w,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [6:0]                           limited_percent
);
    import rpal_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rpal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rpal_datapath #(
        .NEUTRAL_NOM_PERCENT (NEUTRAL_NOM_PERCENT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .requested_percent (requested_percent),
        .assist_mode       (assist_mode),
        .engine_rpm        (engine_rpm),
        .now_ms            (now_ms),
        .link_up           (link_up),
        .battery_power_w   (battery_power_w),
        .cmd               (cmd),
        .status            (status),
        .limited_percent   (limited_percent)
    );

endmodule

`default_nettype wire

FILE: src/rpal_divider.sv
// Serial restoring divider of the rpm assist power limiter, one quotient bit a cycle.
// Depends on rpal_pkg and the assertion macros header.
`default_nettype none
`include "rpm_assist_power_limiter_defines.svh"

module rpal_divider (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [rpal_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [rpal_pkg::DIV_DEN_W-1:0] den,
    output logic                                done,
    output logic [rpal_pkg::DIV_NUM_W-1:0]      quot
);
    import rpal_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    always_comb
    begin
        rem_sh    = {rem_reg[DIV_DEN_W-1:0], num_reg[DIV_NUM_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            num_next = {num_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

    `RPAL_ASSERT_IMM(a_start_when_free, start, !busy_reg)
    `RPAL_ASSERT_NXT(a_start_goes_busy, start, busy_reg && !done_reg)
    `RPAL_ASSERT_IMM(a_done_ends_busy, done_reg, !busy_reg && $past(busy_reg))

endmodule

`default_nettype wire

FILE: src/rpal_datapath.sv
// Datapath of the rpm assist power limiter: configuration and state registers,
// the limiting arithmetic and the shared divider. Depends on rpal_pkg and rpal_divider.
`default_nettype none

module rpal_datapath #(
    parameter int NEUTRAL_NOM_PERCENT = rpal_pkg::NEUTRAL_NOM_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rpal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rpal_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [6:0]                      requested_percent,
    input  wire logic                            assist_mode,
    input  wire logic [15:0]                     engine_rpm,
    input  wire logic [31:0]                     now_ms,
    input  wire logic                            link_up,
    input  wire logic signed [15:0]              battery_power_w,
    input  wire rpal_pkg::dp_cmd_t               cmd,
    output rpal_pkg::dp_status_t                 status,
    output logic [6:0]                           limited_percent
);
    import rpal_pkg::*;

    logic [13:0] start_reg;
    logic [12:0] window_reg;
    logic [10:0] hyst_reg;
    logic [14:0] plim_reg;
    logic [6:0]  nm_reg;
    logic [13:0] ramp_reg;
    logic [13:0] cut_reg;
    logic        en_reg;

    logic              limiting_reg, limiting_next;
    logic [31:0]       trans_ms_reg, trans_ms_next;
    logic [7:0]        last_reg, last_next;
    logic [31:0]       adj_ms_reg, adj_ms_next;
    logic              started_reg, started_next;

    logic [6:0]        req_reg;
    logic              assist_reg;
    logic [15:0]       rpm_reg;
    logic [31:0]       now_reg;
    logic              link_reg;
    logic signed [15:0] pwr_reg;

    logic [7:0]        work_reg, work_next;
    logic [7:0]        t60_reg, t70_reg, ceil_reg;
    logic [6:0]        scale_reg;
    logic signed [9:0] qb_reg;
    logic              neg_reg;
    div_sel_t          sel_reg;
    logic [6:0]        out_reg;

    logic                 allowed, enter, leave;
    logic signed [16:0]   low_thr, rpm_s;
    logic [16:0]          high_thr;
    logic [14:0]          end_rpm;

    logic signed [16:0]   op_a;
    logic signed [8:0]    op_b;
    logic signed [25:0]   prod;
    logic [25:0]          prod_mag;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic signed [DIV_NUM_W:0] qs;
    logic [7:0]           t_value;

    logic [7:0]           l1;
    logic signed [17:0]   err;
    logic                 due;
    logic [7:0]           red;
    logic signed [9:0]    diff;
    logic signed [10:0]   tgt;
    logic [7:0]           blend_value;
    logic [7:0]           last_f, lim_f;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= 14'd1500;
            window_reg <= 13'd500;
            hyst_reg   <= 11'd100;
            plim_reg   <= 15'd13000;
            nm_reg     <= 7'd55;
            ramp_reg   <= 14'd5200;
            cut_reg    <= 14'd5500;
            en_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIMIT_START:  start_reg  <= cfg_data[13:0];
                CFG_LIMIT_WINDOW: window_reg <= cfg_data[12:0];
                CFG_LIMIT_HYST:   hyst_reg   <= cfg_data[10:0];
                CFG_POWER_LIMIT:  plim_reg   <= cfg_data[14:0];
                CFG_NEUTRAL_MAX:  nm_reg     <= cfg_data[6:0];
                CFG_RAMP_START:   ramp_reg   <= cfg_data[13:0];
                CFG_CUTOFF:       cut_reg    <= cfg_data[13:0];
                CFG_HIGH_ENABLE:  en_reg     <= cfg_data[0];
            endcase
        end
    end

    // Entry to and exit from low-rpm limiting.
    always_comb
    begin
        allowed  = (now_reg - trans_ms_reg) > HOLD_OFF_MS;
        low_thr  = $signed({3'b0, start_reg}) - $signed({6'b0, hyst_reg});
        rpm_s    = $signed({1'b0, rpm_reg});
        enter    = rpm_s < low_thr;
        high_thr = {3'b0, start_reg} + {4'b0, window_reg} + {6'b0, hyst_reg};
        leave    = {1'b0, rpm_reg} > high_thr;
        end_rpm  = {1'b0, start_reg} + {2'b0, window_reg};
    end

    // Divider operands.
    always_comb
    begin
        op_a    = $signed({10'b0, req_reg}) - $signed({10'b0, nm_reg});
        op_b    = $signed({1'b0, CEIL_LINK_DOWN}) - $signed({2'b0, nm_reg});
        div_den = DIV_DEN_W'(FULL_PERCENT) - DIV_DEN_W'(nm_reg);
        unique case (cmd.div_sel)
            SEL_T60:
            begin
                op_b = $signed({1'b0, CEIL_LINK_DOWN}) - $signed({2'b0, nm_reg});
            end
            SEL_T70:
            begin
                op_b = $signed({1'b0, CEIL_LINK_UP}) - $signed({2'b0, nm_reg});
            end
            SEL_SCALE:
            begin
                op_a    = $signed({1'b0, rpm_reg}) - $signed({3'b0, start_reg});
                op_b    = $signed({1'b0, FULL_PERCENT});
                div_den = {2'b0, window_reg};
            end
            SEL_BLEND:
            begin
                op_a    = $signed({10'b0, req_reg}) - $signed({9'b0, work_reg});
                op_b    = $signed({2'b0, scale_reg});
                div_den = DIV_DEN_W'(FULL_PERCENT);
            end
            SEL_CEIL:
            begin
                op_a    = $signed({1'b0, rpm_reg}) - $signed({3'b0, ramp_reg});
                op_b    = $signed({2'b0, nm_reg}) - $signed({1'b0, FULL_PERCENT});
                div_den = {1'b0, cut_reg} - {1'b0, ramp_reg};
            end
            default:
            begin
                op_a = '0;
            end
        endcase
        prod     = op_a * op_b;
        prod_mag = prod[25] ? 26'(-prod) : 26'(prod);
        div_num  = prod_mag[DIV_NUM_W-1:0];
    end

    rpal_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        qs      = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        t_value = ({1'b0, req_reg} > {1'b0, nm_reg}) ? (qs[7:0] + {1'b0, nm_reg})
                                                     : {1'b0, req_reg};
    end

    // Power nudging or slewing, computed in the limit step.
    always_comb
    begin
        l1           = last_reg;
        started_next = started_reg;
        adj_ms_next  = adj_ms_reg;
        err          = $signed({{2{pwr_reg[15]}}, pwr_reg}) - $signed({3'b0, plim_reg});
        due          = (now_reg - adj_ms_reg) >= ADJUST_MS;
        red          = (err > ERR_HIGH3) ? 8'd3 : ((err > ERR_HIGH2) ? 8'd2 : 8'd1);
        diff         = '0;
        if (limiting_reg)
        begin
            if (link_reg)
            begin
                if (!started_reg)
                begin
                    l1 = t60_reg;
                    started_next = 1'b1;
                end
                if (pwr_reg > 16'sd0)
                begin
                    if (err > ERR_HIGH1)
                    begin
                        if (due)
                        begin
                            adj_ms_next = now_reg;
                            if (l1 > FLOOR_PERCENT + red)
                            begin
                                l1 = l1 - red;
                            end
                        end
                    end
                    else if (err < ERR_LOW)
                    begin
                        if (due)
                        begin
                            adj_ms_next = now_reg;
                            if (l1 < t70_reg && l1 < TOP_STEP_PERCENT)
                            begin
                                l1 = l1 + 8'd1;
                            end
                        end
                    end
                end
                else
                begin
                    l1 = {1'b0, req_reg};
                end
            end
            else if (req_reg > nm_reg)
            begin
                diff = $signed({2'b0, t60_reg}) - $signed({2'b0, last_reg});
                if (diff > 10'sd2 || diff < -10'sd2)
                begin
                    l1 = (diff > 10'sd0) ? last_reg + 8'd1 : last_reg - 8'd1;
                end
                else
                begin
                    l1 = t60_reg;
                end
            end
            else
            begin
                l1 = {1'b0, req_reg};
            end
        end
        else
        begin
            diff = $signed({3'b0, req_reg}) - $signed({2'b0, last_reg});
            if (diff > 10'sd3)
            begin
                l1 = last_reg + 8'd1;
            end
            else if (diff < -10'sd3)
            begin
                l1 = last_reg - 8'd2;
            end
            else
            begin
                l1 = {1'b0, req_reg};
            end
        end
    end

    // Blend across the rpm window.
    always_comb
    begin
        tgt = $signed({3'b0, work_reg}) + $signed({qb_reg[9], qb_reg});
        if (tgt > $signed({3'b0, work_reg}))
        begin
            blend_value = (tgt - $signed({3'b0, work_reg}) > 11'sd1) ? work_reg + 8'd1
                                                                      : tgt[7:0];
        end
        else if (tgt < $signed({3'b0, work_reg}))
        begin
            blend_value = ($signed({3'b0, work_reg}) - tgt > 11'sd2) ? work_reg - 8'd2
                                                                      : tgt[7:0];
        end
        else
        begin
            blend_value = tgt[7:0];
        end
    end

    // High-rpm rampdown and cutoff.
    always_comb
    begin
        last_f = work_reg;
        lim_f  = work_reg;
        if (en_reg)
        begin
            if (rpm_reg >= {2'b0, cut_reg})
            begin
                last_f = (work_reg > 8'(NEUTRAL_NOM_PERCENT + 2)) ? work_reg - 8'd2
                                                                 : 8'(NEUTRAL_NOM_PERCENT);
                lim_f  = last_f;
            end
            else if (rpm_reg >= {2'b0, ramp_reg})
            begin
                if (work_reg > ceil_reg)
                begin
                    lim_f  = ({1'b0, work_reg} > {1'b0, ceil_reg} + 9'd2) ? work_reg - 8'd2
                                                                         : ceil_reg;
                    last_f = lim_f;
                end
            end
        end
    end

    always_comb
    begin
        limiting_next = limiting_reg;
        trans_ms_next = trans_ms_reg;
        last_next     = last_reg;
        work_next     = work_reg;
        if (cmd.trans)
        begin
            if (!limiting_reg && enter && allowed)
            begin
                limiting_next = 1'b1;
                trans_ms_next = now_reg;
            end
            else if (limiting_reg && leave && allowed)
            begin
                limiting_next = 1'b0;
                trans_ms_next = now_reg;
            end
        end
        if (cmd.limit)
        begin
            work_next = l1;
        end
        if (cmd.blend)
        begin
            work_next = blend_value;
        end
        if (cmd.fin && assist_reg)
        begin
            last_next = last_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limiting_reg <= 1'b0;
            trans_ms_reg <= '0;
            last_reg     <= 8'd50;
            adj_ms_reg   <= '0;
            started_reg  <= 1'b0;
        end
        else
        begin
            limiting_reg <= limiting_next;
            trans_ms_reg <= trans_ms_next;
            last_reg     <= last_next;
            if (cmd.trans && (limiting_next != limiting_reg))
            begin
                started_reg <= 1'b0;
            end
            else if (cmd.limit)
            begin
                started_reg <= started_next;
            end
            if (cmd.limit)
            begin
                adj_ms_reg <= adj_ms_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (cmd.load)
        begin
            req_reg    <= (requested_percent > 7'd100) ? 7'd100 : requested_percent;
            assist_reg <= assist_mode;
            rpm_reg    <= engine_rpm;
            now_reg    <= now_ms;
            link_reg   <= link_up;
            pwr_reg    <= battery_power_w;
        end
        if (cmd.div_start)
        begin
            neg_reg <= prod[25];
            sel_reg <= cmd.div_sel;
        end
        if (div_done)
        begin
            unique case (sel_reg)
                SEL_T60:   t60_reg   <= t_value;
                SEL_T70:   t70_reg   <= t_value;
                SEL_SCALE: scale_reg <= qs[6:0];
                SEL_BLEND: qb_reg    <= qs[9:0];
                SEL_CEIL:  ceil_reg  <= qs[7:0] + FULL_PERCENT;
                default:   scale_reg <= scale_reg;
            endcase
        end
        if (cmd.fin)
        begin
            if (!assist_reg)
            begin
                out_reg <= req_reg;
            end
            else
            begin
                out_reg <= (lim_f > FULL_PERCENT) ? FULL_PERCENT[6:0] : lim_f[6:0];
            end
        end
    end

    always_comb
    begin
        status.assist    = assist_reg;
        status.in_window = limiting_reg && (rpm_reg >= {2'b0, start_reg})
                           && ({1'b0, rpm_reg} < {2'b0, end_rpm});
        status.in_ramp   = en_reg && (rpm_reg < {2'b0, cut_reg})
                           && (rpm_reg >= {2'b0, ramp_reg});
        status.div_done  = div_done;
    end

    assign limited_percent = out_reg;

endmodule

`default_nettype wire

FILE: src/rpal_ctrl.sv
// Controller of the rpm assist power limiter: sequences the datapath steps
// and the shared divider, and holds the handshakes. Depends on rpal_pkg.
`default_nettype none

module rpal_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire rpal_pkg::dp_status_t status,
    output rpal_pkg::dp_cmd_t         cmd
);
    import rpal_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRANS = 4'd1;
    localparam logic [3:0] S_D60   = 4'd2;
    localparam logic [3:0] S_W60   = 4'd3;
    localparam logic [3:0] S_D70   = 4'd4;
    localparam logic [3:0] S_W70   = 4'd5;
    localparam logic [3:0] S_LIMIT = 4'd6;
    localparam logic [3:0] S_DSC   = 4'd7;
    localparam logic [3:0] S_WSC   = 4'd8;
    localparam logic [3:0] S_DBL   = 4'd9;
    localparam logic [3:0] S_WBL   = 4'd10;
    localparam logic [3:0] S_BLEND = 4'd11;
    localparam logic [3:0] S_DCE   = 4'd12;
    localparam logic [3:0] S_WCE   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       fin_ok;

    always_comb
    begin
        cmd            = '0;
        cmd.div_sel    = SEL_T60;
        state_next     = state_reg;
        fin_ok         = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TRANS;
                end
            end
            S_TRANS:
            begin
                if (status.assist)
                begin
                    cmd.trans  = 1'b1;
                    state_next = S_D60;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_D60:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_T60;
                state_next    = S_W60;
            end
            S_W60:
            begin
                if (status.div_done)
                begin
                    state_next = S_D70;
                end
            end
            S_D70:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_T70;
                state_next    = S_W70;
            end
            S_W70:
            begin
                if (status.div_done)
                begin
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                cmd.limit = 1'b1;
                if (status.in_window)
                begin
                    state_next = S_DSC;
                end
                else if (status.in_ramp)
                begin
                    state_next = S_DCE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DSC:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_SCALE;
                state_next    = S_WSC;
            end
            S_WSC:
            begin
                if (status.div_done)
                begin
                    state_next = S_DBL;
                end
            end
            S_DBL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_BLEND;
                state_next    = S_WBL;
            end
            S_WBL:
            begin
                if (status.div_done)
                begin
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = status.in_ramp ? S_DCE : S_FIN;
            end
            S_DCE:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_CEIL;
                state_next    = S_WCE;
            end
            S_WCE:
            begin
                if (status.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_ok)
                begin
                    cmd.fin        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: tb/rpal_checker.sv
// Checker for the rpm assist power limiter: follows register writes and both item channels,
// predicts each limited percent and compares it with what the block returns.
// Depends on rpal_pkg only.
`timescale 1ns / 100ps
`default_nettype none

module rpal_checker #(
    parameter int NEUTRAL = rpal_pkg::NEUTRAL_NOM_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rpal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rpal_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [6:0]                      requested_percent,
    input  wire logic                            assist_mode,
    input  wire logic [15:0]                     engine_rpm,
    input  wire logic [31:0]                     now_ms,
    input  wire logic                            link_up,
    input  wire logic signed [15:0]              battery_power_w,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [6:0]                      limited_percent,
    output int                                   error_count,
    output int                                   pending_count,
    output int                                   result_count
);
    import rpal_pkg::*;

    int start_rpm, window_rpm, hyst_rpm, power_limit, neutral_max;
    int ramp_rpm, cutoff_rpm, high_enable;

    logic        limiting;
    logic [31:0] trans_ms;
    logic [7:0]  last_pct;
    logic [31:0] adjust_ms;
    logic        started;

    logic [6:0] expected_pct[$];

    function automatic int lin_map(int x, int a, int b, int c, int d);
        int den;
        den = b - a;
        if (den == 0)
            return c;
        return ((x - a) * (d - c)) / den + c;
    endfunction

    function automatic logic [7:0] assist_target(int req, int ceiling);
        if (req > neutral_max)
            return 8'(lin_map(req, neutral_max, 100, neutral_max, ceiling));
        return 8'(req);
    endfunction

    function automatic logic [6:0] predict_percent(int req_in, logic assist, int rpm,
                                                   logic [31:0] now, logic link, int power);
        int          req, rpm_end, lim, err, red, tgt, diff, l, scale, ceil_pct;
        logic [7:0]  last;
        logic        allowed, due;
        req = req_in > 100 ? 100 : req_in;
        if (!assist)
            return 7'(req);
        rpm_end = start_rpm + window_rpm;
        allowed = (now - trans_ms) > 32'd500;
        if (!limiting) begin
            if (rpm < start_rpm - hyst_rpm && allowed) begin
                limiting = 1'b1;
                trans_ms = now;
                started  = 1'b0;
            end
        end else if (rpm > rpm_end + hyst_rpm && allowed) begin
            limiting = 1'b0;
            trans_ms = now;
            started  = 1'b0;
        end

        last = last_pct;
        if (limiting) begin
            if (link) begin
                if (!started) begin
                    last    = assist_target(req, 60);
                    started = 1'b1;
                end
                if (power > 0) begin
                    err = power - power_limit;
                    due = (now - adjust_ms) >= 32'd200;
                    if (err > 500) begin
                        if (due) begin
                            adjust_ms = now;
                            red = err > 4000 ? 3 : (err > 2000 ? 2 : 1);
                            if (int'(last) > 10 + red)
                                last = last - 8'(red);
                        end
                    end else if (err < -1000) begin
                        if (due) begin
                            adjust_ms = now;
                            tgt = assist_target(req, 70);
                            if (int'(last) < tgt && last < 8'd95)
                                last = last + 8'd1;
                        end
                    end
                end else begin
                    last = 8'(req);
                end
            end else if (req > neutral_max) begin
                tgt  = assist_target(req, 60);
                diff = tgt - int'(last);
                if (diff > 2 || diff < -2)
                    last = diff > 0 ? last + 8'd1 : last - 8'd1;
                else
                    last = 8'(tgt);
            end else begin
                last = 8'(req);
            end
            lim = last;
            if (rpm >= start_rpm && rpm < rpm_end) begin
                scale = lin_map(rpm, start_rpm, rpm_end, 0, 100);
                tgt   = lim + ((req - lim) * scale) / 100;
                l     = last;
                if (tgt > l)
                    last = 8'(tgt - l > 1 ? l + 1 : tgt);
                else if (tgt < l)
                    last = 8'(l - tgt > 2 ? l - 2 : tgt);
                else
                    last = 8'(tgt);
            end
        end else begin
            diff = req - int'(last);
            if (diff > 3)
                last = last + 8'd1;
            else if (diff < -3)
                last = last - 8'd2;
            else
                last = 8'(req);
        end
        lim = last;

        if (high_enable != 0) begin
            if (rpm >= cutoff_rpm) begin
                if (int'(last) > NEUTRAL + 2)
                    last = last - 8'd2;
                else
                    last = 8'(NEUTRAL);
                lim = last;
            end else if (rpm >= ramp_rpm) begin
                ceil_pct = int'(8'(lin_map(rpm, ramp_rpm, cutoff_rpm, 100, neutral_max)));
                if (lim > ceil_pct) begin
                    if (lim > ceil_pct + 2)
                        lim = int'(8'(last - 8'd2));
                    else
                        lim = ceil_pct;
                    last = 8'(lim);
                end
            end
        end

        last_pct = last;
        if (lim > 100)
            lim = 100;
        if (lim < 0)
            lim = 0;
        return 7'(lim);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_rpm   = 1500;
            window_rpm  = 500;
            hyst_rpm    = 100;
            power_limit = 13000;
            neutral_max = 55;
            ramp_rpm    = 5200;
            cutoff_rpm  = 5500;
            high_enable = 1;
            limiting    = 1'b0;
            trans_ms    = '0;
            last_pct    = 8'd50;
            adjust_ms   = '0;
            started     = 1'b0;
            expected_pct.delete();
            pending_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LIMIT_START:  start_rpm   = cfg_data[13:0];
                    CFG_LIMIT_WINDOW: window_rpm  = cfg_data[12:0];
                    CFG_LIMIT_HYST:   hyst_rpm    = cfg_data[10:0];
                    CFG_POWER_LIMIT:  power_limit = cfg_data[14:0];
                    CFG_NEUTRAL_MAX:  neutral_max = cfg_data[6:0];
                    CFG_RAMP_START:   ramp_rpm    = cfg_data[13:0];
                    CFG_CUTOFF:       cutoff_rpm  = cfg_data[13:0];
                    CFG_HIGH_ENABLE:  high_enable = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                result_count++;
                if (expected_pct.size() == 0)
                    report_mismatch("unexpected item", limited_percent, -1);
                else if (limited_percent !== expected_pct[0])
                    report_mismatch("limited_percent", limited_percent, expected_pct.pop_front());
                else
                    void'(expected_pct.pop_front());
            end
            if (in_valid && !in_stall)
                expected_pct.push_back(predict_percent(requested_percent, assist_mode,
                    engine_rpm, now_ms, link_up, battery_power_w));
            pending_count = expected_pct.size();
        end
    end

    initial
    begin
        error_count  = 0;
        result_count = 0;
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Top of the rpm assist power limiter testbench: clock, reset, register settings and items.
// Depends on rpal_pkg, rpm_assist_power_limiter and rpal_checker.
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import rpal_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [6:0]            requested_percent;
    logic                  assist_mode;
    logic [15:0]           engine_rpm;
    logic [31:0]           now_ms;
    logic                  link_up;
    logic signed [15:0]    battery_power_w;
    logic                  out_valid;
    logic                  out_stall;
    logic [6:0]            limited_percent;

    int error_count, pending_count, result_count;
    int cycle_count;
    int sent_count;
    logic quiet;
    logic calm;
    int stall_left;

    int start_rpm, window_rpm, hyst_rpm, power_limit, cutoff_rpm;
    int rpm_now;
    logic [31:0] clock_ms;

    rpm_assist_power_limiter u_top (.*);

    rpal_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (quiet || calm) begin
            out_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            out_stall  = ($urandom_range(0, 2) == 0);
            stall_left = $urandom_range(1, 10);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(int st, int win, int hy, int pw, int nm, int rs, int co,
                                  int en);
        write_reg(CFG_LIMIT_START, st);
        write_reg(CFG_LIMIT_WINDOW, win);
        write_reg(CFG_LIMIT_HYST, hy);
        write_reg(CFG_POWER_LIMIT, pw);
        write_reg(CFG_NEUTRAL_MAX, nm);
        write_reg(CFG_RAMP_START, rs);
        write_reg(CFG_CUTOFF, co);
        write_reg(CFG_HIGH_ENABLE, en);
        start_rpm   = st;
        window_rpm  = win;
        hyst_rpm    = hy;
        power_limit = pw;
        cutoff_rpm  = co;
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance, now and then after an idle gap.
    task automatic send_item(int req, logic assist, int rpm, logic [31:0] now, logic link,
                             int power);
        in_valid          = 1'b1;
        requested_percent = 7'(req);
        assist_mode       = assist;
        engine_rpm        = 16'(rpm);
        now_ms            = now;
        link_up           = link;
        battery_power_w   = 16'(power);
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10))
                @(negedge clk);
        end
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (150)
            @(negedge clk);
    endtask

    task automatic random_items(int count);
        int lo, hi, power;
        lo = start_rpm > hyst_rpm + 800 ? start_rpm - hyst_rpm - 800 : 0;
        hi = start_rpm + window_rpm + hyst_rpm + 800;
        if (hi < cutoff_rpm + 400)
            hi = cutoff_rpm + 400;
        if (hi > 65535)
            hi = 65535;
        rpm_now = $urandom_range(lo, hi);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item($urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 65535),
                          $urandom, $urandom_range(0, 1), $urandom_range(0, 65535) - 32768);
            end else begin
                rpm_now += $urandom_range(0, 800) - 400;
                if (rpm_now < lo)
                    rpm_now = lo;
                if (rpm_now > hi)
                    rpm_now = hi;
                clock_ms += $urandom_range(0, 300);
                power = power_limit + $urandom_range(0, 12000) - 6000;
                if ($urandom_range(0, 9) == 0)
                    power = -$urandom_range(0, 32768);
                if (power > 32767)
                    power = 32767;
                send_item($urandom_range(0, 100), $urandom_range(0, 19) != 0, rpm_now, clock_ms,
                          $urandom_range(0, 4) != 0, power);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        requested_percent = '0;
        assist_mode = 1'b0;
        engine_rpm = '0;
        now_ms = '0;
        link_up = 1'b0;
        battery_power_w = '0;
        out_stall = 1'b0;
        stall_left = 0;
        quiet = 1'b0;
        calm = 1'b0;
        cycle_count = 0;
        sent_count = 0;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;

        apply_settings(1500, 500, 100, 13000, 55, 5200, 5500, 1);
        @(negedge clk);
        send_item(0, 1'b0, 0, 32'd0, 1'b0, 0);
        send_item(127, 1'b0, 65535, 32'hFFFF_FFFF, 1'b1, -32768);
        send_item(100, 1'b1, 3000, 32'd10, 1'b1, 32767);
        send_item(120, 1'b1, 800, 32'd600, 1'b1, 32767);
        send_item(100, 1'b1, 800, 32'd900, 1'b1, 20000);
        send_item(100, 1'b1, 800, 32'd1100, 1'b1, 15000);
        send_item(90, 1'b1, 800, 32'd1300, 1'b1, 13200);
        send_item(90, 1'b1, 800, 32'd1500, 1'b1, 5000);
        send_item(90, 1'b1, 800, 32'd1700, 1'b1, -32768);
        send_item(90, 1'b1, 800, 32'd1800, 1'b0, 0);
        send_item(30, 1'b1, 800, 32'd1900, 1'b0, 0);
        send_item(100, 1'b1, 1600, 32'd2000, 1'b0, 0);
        send_item(100, 1'b1, 1750, 32'd2100, 1'b1, 0);
        send_item(100, 1'b1, 2700, 32'd2700, 1'b1, 0);
        send_item(100, 1'b1, 5300, 32'd2800, 1'b1, 0);
        send_item(100, 1'b1, 5499, 32'd2900, 1'b1, 0);
        send_item(100, 1'b1, 5500, 32'd3000, 1'b1, 0);
        send_item(0, 1'b1, 65535, 32'hFFFF_FF00, 1'b1, 0);
        send_item(100, 1'b1, 100, 32'd200, 1'b1, 32767);
        send_item(55, 1'b1, 100, 32'd300, 1'b1, 1);
        clock_ms = $urandom;
        random_items(255);
        drain();

        apply_settings(0, 1, 0, 0, 0, 0, 1, 1);
        random_items(255);
        drain();

        calm = 1'b1;
        apply_settings(16000, 8000, 2000, 30000, 99, 16000, 16000, 1);
        clock_ms = $urandom;
        random_items(255);
        drain();
        calm = 1'b0;

        apply_settings(3000, 0, 0, 8000, 70, 4000, 4000, 0);
        random_items(255);
        drain();

        apply_settings(2000, 1000, 300, 5000, 20, 6000, 5000, 1);
        clock_ms = $urandom;
        random_items(255);
        drain();

        apply_settings(1000, 2000, 50, 20000, 50, 3000, 3000, 1);
        random_items(150);
        quiet = 1'b1;
        random_items(105);
        drain();

        $display("Sent %0d items over six register settings; %0d results checked.",
                 sent_count, result_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: rpm_assist_power_limiter.f
+incdir+src
src/rpal_pkg.sv
src/rpal_divider.sv
src/rpal_datapath.sv
src/rpal_ctrl.sv
src/rpm_assist_power_limiter.sv
tb/rpal_checker.sv
tb/tb.sv
